>>> hdl/p3pt_pkg.sv
`default_nettype none
// ============================================================================
// p3pt_pkg
// Shared widths, constants and types of the plane from three points unit.
// ============================================================================
package p3pt_pkg;

   // Point coordinates: signed, 8 fraction bits.
   localparam int COORD_WIDTH = 24;

   localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;
   localparam int MAG_WIDTH   = PROD_WIDTH;
   localparam int NORM_STEPS  = $clog2(MAG_WIDTH);

   localparam int NORM_FRAC    = 30;
   localparam int SCALE_WIDTH  = NORM_FRAC;
   localparam int SQUARE_WIDTH = 2 * SCALE_WIDTH;
   localparam int SUMSQ_WIDTH  = SQUARE_WIDTH + 2;
   localparam int LEN_WIDTH    = SUMSQ_WIDTH / 2;
   localparam int QUOT_WIDTH   = NORM_FRAC + 1;
   localparam int DIV_WIDTH    = SUMSQ_WIDTH;

   localparam int NORMAL_WIDTH   = 32;
   localparam int OFFSET_WIDTH   = 26;
   localparam int DOT_PROD_WIDTH = NORMAL_WIDTH + COORD_WIDTH;
   localparam int DOT_WIDTH      = DOT_PROD_WIDTH + 2;

   localparam int QUEUE_DEPTH     = 8;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = QUEUE_PTR_WIDTH + 1;
   localparam int FRONT_CNT_WIDTH = 2;

   localparam logic [QUOT_WIDTH-1:0] UNIT_QUOT = QUOT_WIDTH'(1) << NORM_FRAC;
   localparam logic [DOT_WIDTH-1:0]  ROUND_HALF = DOT_WIDTH'(1) << (NORM_FRAC - 1);
   localparam logic [DOT_WIDTH-1:0]  OFFSET_NEG_LIMIT = DOT_WIDTH'(1) << (OFFSET_WIDTH - 1);
   localparam logic [DOT_WIDTH-1:0]  OFFSET_POS_LIMIT = OFFSET_NEG_LIMIT - DOT_WIDTH'(1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // One request after the cross product, as it waits in the queue.
   typedef struct packed {
      logic [2:0]                neg;
      logic [2:0][MAG_WIDTH-1:0] mag;
      logic                      degenerate;
      coord_type                 fx;
      coord_type                 fy;
      coord_type                 fz;
   } cross_type;

   // Fields that ride along the back pipeline unchanged.
   typedef struct packed {
      logic [2:0] neg;
      logic       degenerate;
      coord_type  fx;
      coord_type  fy;
      coord_type  fz;
   } carry_type;

   typedef struct packed {
      logic [FRONT_CNT_WIDTH-1:0] in_flight;
   } front_status_type;

   typedef struct packed {
      logic [QUEUE_CNT_WIDTH-1:0] count;
   } queue_status_type;

endpackage
`default_nettype wire

>>> hdl/plane_from_three_points_unit.sv
`default_nettype none
// ============================================================================
// plane_from_three_points_unit
// Plane through three fixed-point points: unit normal and offset.
// ============================================================================
//
//   Channel   Handshake          Ports
//   --------  -----------------  ---------------------------------------------
//   request   start && !busy     req_first_*, req_second_*, req_third_*
//   response  rsp_strobe pulse   rsp_normal_x/y/z, rsp_plane_offset,
//                                rsp_degenerate
//
// A request may be taken on every clock cycle while busy is low. Each request
// gives exactly one response, in request order. Most of the pipeline lies in
// the bit-per-stage square root (31 stages) and the three bit-per-stage
// dividers (31 stages). Reset is synchronous and clears only the valid
// pipeline, the queue pointers and the queue count. The response side cannot
// stall; busy rises only if the queue between the front and back parts could
// overflow, which the free-running back part prevents in practice.
//
// The front part forms the edge vectors and the exact cross product, and flags
// collinear points. The back part scales the normal by a common power of two,
// takes the floor square root of its squared length, divides each component
// by that length, and computes the rounded, saturated plane offset.
// ============================================================================
module plane_from_three_points_unit import p3pt_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [COORD_WIDTH-1:0]  req_first_x,
   input  logic signed [COORD_WIDTH-1:0]  req_first_y,
   input  logic signed [COORD_WIDTH-1:0]  req_first_z,
   input  logic signed [COORD_WIDTH-1:0]  req_second_x,
   input  logic signed [COORD_WIDTH-1:0]  req_second_y,
   input  logic signed [COORD_WIDTH-1:0]  req_second_z,
   input  logic signed [COORD_WIDTH-1:0]  req_third_x,
   input  logic signed [COORD_WIDTH-1:0]  req_third_y,
   input  logic signed [COORD_WIDTH-1:0]  req_third_z,
   output logic                           rsp_strobe,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_x,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_y,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_z,
   output logic signed [OFFSET_WIDTH-1:0] rsp_plane_offset,
   output logic                           rsp_degenerate
);

   logic             accept;
   logic             push;
   cross_type        push_entry;
   logic             pop_valid;
   cross_type        pop_entry;
   front_status_type front_status;
   queue_status_type queue_status;
   logic [QUEUE_CNT_WIDTH:0] committed;

   // Count every request that may still land in the queue: those waiting there
   // and those still inside the front part.
   assign committed = (QUEUE_CNT_WIDTH + 1)'(queue_status.count)
                      + (QUEUE_CNT_WIDTH + 1)'(front_status.in_flight);
   assign busy      = (committed >= (QUEUE_CNT_WIDTH + 1)'(QUEUE_DEPTH));
   assign accept    = start && !busy;

   p3pt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .first_x    (req_first_x),
      .first_y    (req_first_y),
      .first_z    (req_first_z),
      .second_x   (req_second_x),
      .second_y   (req_second_y),
      .second_z   (req_second_z),
      .third_x    (req_third_x),
      .third_y    (req_third_y),
      .third_z    (req_third_z),
      .push       (push),
      .push_entry (push_entry),
      .status     (front_status)
   );

   p3pt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   p3pt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (pop_valid),
      .in_entry         (pop_entry),
      .rsp_strobe       (rsp_strobe),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_plane_offset (rsp_plane_offset),
      .rsp_degenerate   (rsp_degenerate)
   );

endmodule
`default_nettype wire

>>> hdl/p3pt_front.sv
`default_nettype none
// ============================================================================
// p3pt_front
// Edge vectors, exact cross product, sign/magnitude split and collinear test.
// ============================================================================
module p3pt_front import p3pt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  coord_type        first_x,
   input  coord_type        first_y,
   input  coord_type        first_z,
   input  coord_type        second_x,
   input  coord_type        second_y,
   input  coord_type        second_z,
   input  coord_type        third_x,
   input  coord_type        third_y,
   input  coord_type        third_z,
   output logic             push,
   output cross_type        push_entry,
   output front_status_type status
);

   // Edge order: ax, ay, az, bx, by, bz.
   logic                         v1_ff;
   logic signed [EDGE_WIDTH-1:0] edge_vec_ff [6];
   logic signed [EDGE_WIDTH-1:0] edge_vec_in [6];
   coord_type                    f1_ff [3];

   logic                         v2_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff [6];
   logic signed [PROD_WIDTH-1:0] prod_in [6];
   coord_type                    f2_ff [3];

   logic                         v3_ff;
   cross_type                    out_ff;
   cross_type                    out_in;
   logic signed [CROSS_WIDTH-1:0] cross_val [3];

   always_comb begin
      edge_vec_in[0] = EDGE_WIDTH'(second_x) - EDGE_WIDTH'(first_x);
      edge_vec_in[1] = EDGE_WIDTH'(second_y) - EDGE_WIDTH'(first_y);
      edge_vec_in[2] = EDGE_WIDTH'(second_z) - EDGE_WIDTH'(first_z);
      edge_vec_in[3] = EDGE_WIDTH'(third_x) - EDGE_WIDTH'(first_x);
      edge_vec_in[4] = EDGE_WIDTH'(third_y) - EDGE_WIDTH'(first_y);
      edge_vec_in[5] = EDGE_WIDTH'(third_z) - EDGE_WIDTH'(first_z);
   end

   always_comb begin
      prod_in[0] = PROD_WIDTH'(edge_vec_ff[1]) * PROD_WIDTH'(edge_vec_ff[5]);
      prod_in[1] = PROD_WIDTH'(edge_vec_ff[2]) * PROD_WIDTH'(edge_vec_ff[4]);
      prod_in[2] = PROD_WIDTH'(edge_vec_ff[2]) * PROD_WIDTH'(edge_vec_ff[3]);
      prod_in[3] = PROD_WIDTH'(edge_vec_ff[0]) * PROD_WIDTH'(edge_vec_ff[5]);
      prod_in[4] = PROD_WIDTH'(edge_vec_ff[0]) * PROD_WIDTH'(edge_vec_ff[4]);
      prod_in[5] = PROD_WIDTH'(edge_vec_ff[1]) * PROD_WIDTH'(edge_vec_ff[3]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cross_val[i] = CROSS_WIDTH'(prod_ff[2*i]) - CROSS_WIDTH'(prod_ff[2*i+1]);
         out_in.neg[i] = cross_val[i][CROSS_WIDTH-1];
         out_in.mag[i] = cross_val[i][CROSS_WIDTH-1] ? MAG_WIDTH'(-cross_val[i])
                                                     : MAG_WIDTH'(cross_val[i]);
      end
      out_in.degenerate = (out_in.mag[0] == '0) && (out_in.mag[1] == '0)
                          && (out_in.mag[2] == '0);
      out_in.fx = f2_ff[0];
      out_in.fy = f2_ff[1];
      out_in.fz = f2_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      edge_vec_ff <= edge_vec_in;
      f1_ff[0]    <= first_x;
      f1_ff[1]    <= first_y;
      f1_ff[2]    <= first_z;
      prod_ff     <= prod_in;
      f2_ff       <= f1_ff;
      out_ff      <= out_in;
   end

   assign push             = v3_ff;
   assign push_entry       = out_ff;
   assign status.in_flight = FRONT_CNT_WIDTH'(v1_ff) + FRONT_CNT_WIDTH'(v2_ff)
                             + FRONT_CNT_WIDTH'(v3_ff);

endmodule
`default_nettype wire

>>> hdl/p3pt_queue.sv
`default_nettype none
// ============================================================================
// p3pt_queue
// Short first-in first-out queue between the front and back parts.
// ============================================================================
module p3pt_queue import p3pt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cross_type        push_entry,
   output logic             pop_valid,
   output cross_type        pop_entry,
   output queue_status_type status
);

   cross_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       pop;

   // The back part never stalls, so any waiting request leaves at once.
   assign pop = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_WIDTH'(push) - QUEUE_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_valid    = pop;
   assign pop_entry    = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule
`default_nettype wire

>>> hdl/p3pt_back.sv
`default_nettype none
// ============================================================================
// p3pt_back
// Block scaling, square root, normalizing divides and plane offset.
// ============================================================================
module p3pt_back import p3pt_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  cross_type                      in_entry,
   output logic                           rsp_strobe,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_x,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_y,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_z,
   output logic signed [OFFSET_WIDTH-1:0] rsp_plane_offset,
   output logic                           rsp_degenerate
);

   carry_type in_carry;

   always_comb begin
      in_carry.neg        = in_entry.neg;
      in_carry.degenerate = in_entry.degenerate;
      in_carry.fx         = in_entry.fx;
      in_carry.fy         = in_entry.fy;
      in_carry.fz         = in_entry.fz;
   end

   // ---------------- block scaling: one shift step per stage ----------------
   logic                      nv_ff   [NORM_STEPS];
   logic [2:0][MAG_WIDTH-1:0] nmag_ff [NORM_STEPS];
   carry_type                 nc_ff   [NORM_STEPS];

   genvar j;
   for (j = 0; j < NORM_STEPS; j++) begin : g_norm
      localparam int K = 1 << (NORM_STEPS - 1 - j);
      logic                      v_src;
      logic [2:0][MAG_WIDTH-1:0] m_src;
      carry_type                 c_src;
      logic [MAG_WIDTH-1:0]      all_bits;
      logic [2:0][MAG_WIDTH-1:0] m_in;

      if (j == 0) begin : g_src
         assign v_src = in_valid;
         assign m_src = in_entry.mag;
         assign c_src = in_carry;
      end else begin : g_src
         assign v_src = nv_ff[j-1];
         assign m_src = nmag_ff[j-1];
         assign c_src = nc_ff[j-1];
      end

      always_comb begin
         all_bits = m_src[0] | m_src[1] | m_src[2];
         if (all_bits[MAG_WIDTH-1 -: K] == '0) begin
            for (int i = 0; i < 3; i++) begin
               m_in[i] = m_src[i] << K;
            end
         end else begin
            m_in = m_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[j] <= 1'b0;
         end else begin
            nv_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         nmag_ff[j] <= m_in;
         nc_ff[j]   <= c_src;
      end
   end

   // ---------------- squares and their sum ----------------
   logic                         sqv_ff;
   logic [2:0][SCALE_WIDTH-1:0]  sqm_ff, sqm_in;
   logic [2:0][SQUARE_WIDTH-1:0] sq_ff, sq_in;
   carry_type                    sqc_ff;

   logic                         smv_ff;
   logic [2:0][SCALE_WIDTH-1:0]  smm_ff;
   logic [SUMSQ_WIDTH-1:0]       sumsq_ff, sumsq_in;
   carry_type                    smc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqm_in[i] = nmag_ff[NORM_STEPS-1][i][MAG_WIDTH-1 -: SCALE_WIDTH];
         sq_in[i]  = SQUARE_WIDTH'(sqm_in[i]) * SQUARE_WIDTH'(sqm_in[i]);
      end
      sumsq_in = SUMSQ_WIDTH'(sq_ff[0]) + SUMSQ_WIDTH'(sq_ff[1])
                 + SUMSQ_WIDTH'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= 1'b0;
         smv_ff <= 1'b0;
      end else begin
         sqv_ff <= nv_ff[NORM_STEPS-1];
         smv_ff <= sqv_ff;
      end
   end

   always_ff @(posedge clock) begin
      sqm_ff   <= sqm_in;
      sq_ff    <= sq_in;
      sqc_ff   <= nc_ff[NORM_STEPS-1];
      smm_ff   <= sqm_ff;
      sumsq_ff <= sumsq_in;
      smc_ff   <= sqc_ff;
   end

   // ---------------- square root: one result bit per stage ----------------
   logic                        rv_ff    [LEN_WIDTH];
   logic [SUMSQ_WIDTH-1:0]      rrem_ff  [LEN_WIDTH];
   logic [LEN_WIDTH-1:0]        rroot_ff [LEN_WIDTH];
   logic [2:0][SCALE_WIDTH-1:0] rm_ff    [LEN_WIDTH];
   carry_type                   rc_ff    [LEN_WIDTH];

   genvar s;
   for (s = 0; s < LEN_WIDTH; s++) begin : g_sqrt
      localparam int B = LEN_WIDTH - 1 - s;
      logic                        v_src;
      logic [SUMSQ_WIDTH-1:0]      rem_src, rem_in, trial;
      logic [LEN_WIDTH-1:0]        root_src, root_in;
      logic [2:0][SCALE_WIDTH-1:0] m_src;
      carry_type                   c_src;

      if (s == 0) begin : g_src
         assign v_src    = smv_ff;
         assign rem_src  = sumsq_ff;
         assign root_src = '0;
         assign m_src    = smm_ff;
         assign c_src    = smc_ff;
      end else begin : g_src
         assign v_src    = rv_ff[s-1];
         assign rem_src  = rrem_ff[s-1];
         assign root_src = rroot_ff[s-1];
         assign m_src    = rm_ff[s-1];
         assign c_src    = rc_ff[s-1];
      end

      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
      always_comb begin
         trial = (SUMSQ_WIDTH'(root_src) << (B + 1)) + (SUMSQ_WIDTH'(1) << (2 * B));
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (LEN_WIDTH'(1) << B);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[s] <= 1'b0;
         end else begin
            rv_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         rrem_ff[s]  <= rem_in;
         rroot_ff[s] <= root_in;
         rm_ff[s]    <= m_src;
         rc_ff[s]    <= c_src;
      end
   end

   // ---------------- dividend set-up ----------------
   logic                       pv_ff;
   logic [2:0][DIV_WIDTH-1:0]  pnum_ff, pnum_in;
   logic [LEN_WIDTH-1:0]       plen_ff;
   carry_type                  pc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pnum_in[i] = (DIV_WIDTH'(rm_ff[LEN_WIDTH-1][i]) << NORM_FRAC)
                      + DIV_WIDTH'(rroot_ff[LEN_WIDTH-1] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= rv_ff[LEN_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      pnum_ff <= pnum_in;
      plen_ff <= rroot_ff[LEN_WIDTH-1];
      pc_ff   <= rc_ff[LEN_WIDTH-1];
   end

   // ---------------- three dividers: one quotient bit per stage ----------------
   logic                       dv_ff   [QUOT_WIDTH];
   logic [2:0][DIV_WIDTH-1:0]  drem_ff [QUOT_WIDTH];
   logic [2:0][QUOT_WIDTH-1:0] dq_ff   [QUOT_WIDTH];
   logic [LEN_WIDTH-1:0]       dlen_ff [QUOT_WIDTH];
   carry_type                  dc_ff   [QUOT_WIDTH];

   for (s = 0; s < QUOT_WIDTH; s++) begin : g_div
      localparam int B = QUOT_WIDTH - 1 - s;
      logic                       v_src;
      logic [2:0][DIV_WIDTH-1:0]  rem_src, rem_in;
      logic [2:0][QUOT_WIDTH-1:0] q_src, q_in;
      logic [LEN_WIDTH-1:0]       len_src;
      carry_type                  c_src;
      logic [DIV_WIDTH-1:0]       divisor;

      if (s == 0) begin : g_src
         assign v_src   = pv_ff;
         assign rem_src = pnum_ff;
         assign q_src   = '0;
         assign len_src = plen_ff;
         assign c_src   = pc_ff;
      end else begin : g_src
         assign v_src   = dv_ff[s-1];
         assign rem_src = drem_ff[s-1];
         assign q_src   = dq_ff[s-1];
         assign len_src = dlen_ff[s-1];
         assign c_src   = dc_ff[s-1];
      end

      always_comb begin
         divisor = DIV_WIDTH'(len_src) << B;
         for (int i = 0; i < 3; i++) begin
            if (rem_src[i] >= divisor) begin
               rem_in[i] = rem_src[i] - divisor;
               q_in[i]   = q_src[i] | (QUOT_WIDTH'(1) << B);
            end else begin
               rem_in[i] = rem_src[i];
               q_in[i]   = q_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else begin
            dv_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         drem_ff[s] <= rem_in;
         dq_ff[s]   <= q_in;
         dlen_ff[s] <= len_src;
         dc_ff[s]   <= c_src;
      end
   end

   // ---------------- signed normal components ----------------
   logic                          nrv_ff;
   logic signed [NORMAL_WIDTH-1:0] nrm_ff [3];
   logic signed [NORMAL_WIDTH-1:0] nrm_in [3];
   carry_type                     nrc_ff;
   logic [QUOT_WIDTH-1:0]         qclamp [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qclamp[i] = (dq_ff[QUOT_WIDTH-1][i] > UNIT_QUOT) ? UNIT_QUOT
                                                          : dq_ff[QUOT_WIDTH-1][i];
         nrm_in[i] = dc_ff[QUOT_WIDTH-1].neg[i] ? -$signed(NORMAL_WIDTH'(qclamp[i]))
                                                : $signed(NORMAL_WIDTH'(qclamp[i]));
      end
   end

   // ---------------- offset: products and sum ----------------
   logic                             opv_ff;
   logic signed [DOT_PROD_WIDTH-1:0] op_ff [3];
   logic signed [DOT_PROD_WIDTH-1:0] op_in [3];
   logic signed [NORMAL_WIDTH-1:0]   opn_ff [3];
   carry_type                        opc_ff;

   logic                             osv_ff;
   logic signed [DOT_WIDTH-1:0]      dot_ff, dot_in;
   logic signed [NORMAL_WIDTH-1:0]   osn_ff [3];
   logic                             osd_ff;

   always_comb begin
      op_in[0] = DOT_PROD_WIDTH'(nrm_ff[0]) * DOT_PROD_WIDTH'(nrc_ff.fx);
      op_in[1] = DOT_PROD_WIDTH'(nrm_ff[1]) * DOT_PROD_WIDTH'(nrc_ff.fy);
      op_in[2] = DOT_PROD_WIDTH'(nrm_ff[2]) * DOT_PROD_WIDTH'(nrc_ff.fz);
      dot_in   = DOT_WIDTH'(op_ff[0]) + DOT_WIDTH'(op_ff[1]) + DOT_WIDTH'(op_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrv_ff <= 1'b0;
         opv_ff <= 1'b0;
         osv_ff <= 1'b0;
      end else begin
         nrv_ff <= dv_ff[QUOT_WIDTH-1];
         opv_ff <= nrv_ff;
         osv_ff <= opv_ff;
      end
   end

   always_ff @(posedge clock) begin
      nrm_ff <= nrm_in;
      nrc_ff <= dc_ff[QUOT_WIDTH-1];
      op_ff  <= op_in;
      opn_ff <= nrm_ff;
      opc_ff <= nrc_ff;
      dot_ff <= dot_in;
      osn_ff <= opn_ff;
      osd_ff <= opc_ff.degenerate;
   end

   // ---------------- result register ----------------
   logic                           rsp_strobe_ff;
   logic signed [NORMAL_WIDTH-1:0] rsp_nx_ff, rsp_nx_in;
   logic signed [NORMAL_WIDTH-1:0] rsp_ny_ff, rsp_ny_in;
   logic signed [NORMAL_WIDTH-1:0] rsp_nz_ff, rsp_nz_in;
   logic signed [OFFSET_WIDTH-1:0] rsp_off_ff, rsp_off_in;
   logic                           rsp_deg_ff;
   logic [DOT_WIDTH-1:0]           dot_mag, rnd;

   // Offset is minus the dot product, rounded half away from zero.
   always_comb begin
      dot_mag = dot_ff[DOT_WIDTH-1] ? DOT_WIDTH'(-dot_ff) : DOT_WIDTH'(dot_ff);
      rnd     = (dot_mag + ROUND_HALF) >> NORM_FRAC;
      if (!dot_ff[DOT_WIDTH-1] && (dot_ff != '0)) begin
         if (rnd > OFFSET_NEG_LIMIT) begin
            rnd = OFFSET_NEG_LIMIT;
         end
         rsp_off_in = OFFSET_WIDTH'(DOT_WIDTH'(0) - rnd);
      end else begin
         if (rnd > OFFSET_POS_LIMIT) begin
            rnd = OFFSET_POS_LIMIT;
         end
         rsp_off_in = OFFSET_WIDTH'(rnd);
      end
      rsp_nx_in = osn_ff[0];
      rsp_ny_in = osn_ff[1];
      rsp_nz_in = osn_ff[2];
      if (osd_ff) begin
         rsp_nx_in  = '0;
         rsp_ny_in  = '0;
         rsp_nz_in  = '0;
         rsp_off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= osv_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_nx_ff  <= rsp_nx_in;
      rsp_ny_ff  <= rsp_ny_in;
      rsp_nz_ff  <= rsp_nz_in;
      rsp_off_ff <= rsp_off_in;
      rsp_deg_ff <= osd_ff;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_normal_x     = rsp_nx_ff;
   assign rsp_normal_y     = rsp_ny_ff;
   assign rsp_normal_z     = rsp_nz_ff;
   assign rsp_plane_offset = rsp_off_ff;
   assign rsp_degenerate   = rsp_deg_ff;

endmodule
`default_nettype wire
